>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL; all checks sample on i_clk and
// are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/fqsr_pkg.sv
package fqsr_pkg;

    localparam int CMD_W   = 3;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_COMPARE,
        OP_SCAN,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] data_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    hit;
        logic [STAT_W-1:0]       status;
        logic [ENTRY_W-1:0]      entry_count;
    } t_out_word;

endpackage

>>> rtl/fqsr_cell.sv
module fqsr_cell
    import fqsr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DEPTH       = 16,
    parameter int IDX         = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_op                      i_op,
    input  logic [$clog2(DEPTH+1)-1:0]    i_pos,
    input  logic [VALUE_WIDTH-1:0]        i_key,
    input  logic [VALUE_WIDTH-1:0]        i_right,
    input  logic [VALUE_WIDTH-1:0]        i_front,
    input  logic                          i_left_seen,
    output logic [VALUE_WIDTH-1:0]        o_slot,
    output logic                          o_seen
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VALUE_WIDTH-1:0] r_slot, n_slot;
    logic                   r_match, n_match;
    logic                   r_seen, n_seen;

    always_comb begin
        n_slot  = r_slot;
        n_match = r_match;
        n_seen  = r_seen;
        case (i_op)
            OP_PUSH: begin
                if (MY_IDX == i_pos) begin
                    n_slot = i_key;
                end
            end
            OP_POP: begin
                n_slot = i_right;
            end
            OP_COMPARE: begin
                // only occupied cells may match
                n_match = (r_slot == i_key) && (MY_IDX < i_pos);
                n_seen  = 1'b0;
            end
            OP_SCAN: begin
                n_seen = r_seen | i_left_seen | r_match;
            end
            OP_REMOVE: begin
                if (r_seen) begin
                    n_slot = i_right;
                end
            end
            OP_ROTATE: begin
                if (MY_IDX < i_pos) begin
                    n_slot = i_right;
                end else if (MY_IDX == i_pos) begin
                    n_slot = i_front;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            r_match <= n_match;
            r_seen  <= n_seen;
        end
    end

    assign o_slot = r_slot;
    assign o_seen = r_seen;

endmodule

>>> rtl/fqsr_ctrl.sv
`include "assert_macros.svh"

module fqsr_ctrl
    import fqsr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DEPTH       = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_in_word                   i_word,
    output logic                       o_stall,
    output logic                       o_valid,
    output t_out_word                  o_word,
    input  logic                       i_stall,
    input  logic [VALUE_WIDTH-1:0]     i_front,
    input  logic                       i_last_seen,
    output t_cell_op                   o_op,
    output logic [$clog2(DEPTH+1)-1:0] o_pos,
    output logic [VALUE_WIDTH-1:0]     o_key
);

    localparam int CW = $clog2(DEPTH+1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_ROTATE
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_occ, n_occ;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_rot, n_rot;
    logic            r_is_remove, n_is_remove;
    logic            r_ovalid, n_ovalid;
    t_out_word       r_oword, n_oword;

    logic            accept;
    logic            out_wr;
    logic            empty;
    logic            pop_take;
    t_out_word       word;

    assign o_stall  = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign accept   = i_valid && !o_stall;
    assign empty    = (r_occ == '0);
    assign pop_take = accept && (i_word.command == CMD_POP) && !empty;
    assign o_key    = VALUE_WIDTH'($signed(i_word.data_value));

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cnt       = r_cnt;
        n_rot       = r_rot;
        n_is_remove = r_is_remove;
        n_ovalid    = r_ovalid;
        n_oword     = r_oword;
        o_op        = OP_HOLD;
        o_pos       = r_occ;
        out_wr      = 1'b0;
        word        = '0;
        word.status = ST_OK;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_word.command) inside
                        CMD_PUSH: begin
                            out_wr = 1'b1;
                            if (r_occ == CW'(DEPTH)) begin
                                word.status = ST_FULL;
                            end else begin
                                o_op  = OP_PUSH;
                                n_occ = r_occ + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            out_wr = 1'b1;
                            if (empty) begin
                                word.status = ST_EMPTY;
                            end else begin
                                o_op           = OP_POP;
                                n_occ          = r_occ - 1'b1;
                                word.out_value = VAL_W'($signed(i_front));
                            end
                        end
                        CMD_SEARCH, CMD_REMOVE: begin
                            if (empty) begin
                                out_wr      = 1'b1;
                                word.status = ST_EMPTY;
                            end else begin
                                o_op        = OP_COMPARE;
                                n_cnt       = '0;
                                n_is_remove = (i_word.command == CMD_REMOVE);
                                n_state     = S_SCAN;
                            end
                        end
                        CMD_REVERSE: begin
                            if (empty) begin
                                out_wr      = 1'b1;
                                word.status = ST_EMPTY;
                            end else if (r_occ == CW'(1)) begin
                                out_wr = 1'b1;
                            end else begin
                                n_rot   = r_occ - 1'b1;
                                n_state = S_ROTATE;
                            end
                        end
                        default: begin
                            out_wr = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // ripple the first-match flag one cell per cycle
                o_op  = OP_SCAN;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IW'(DEPTH-1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                out_wr   = 1'b1;
                word.hit = i_last_seen;
                if (r_is_remove && i_last_seen) begin
                    o_op  = OP_REMOVE;
                    n_occ = r_occ - 1'b1;
                end
                n_state = S_IDLE;
            end
            S_ROTATE: begin
                // rotate the leading r_rot+1 entries left by one
                o_op  = OP_ROTATE;
                o_pos = r_rot;
                n_rot = r_rot - 1'b1;
                if (r_rot == CW'(1)) begin
                    out_wr  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_wr) begin
            word.entry_count = ENTRY_W'(n_occ);
            n_ovalid         = 1'b1;
            n_oword          = word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_rot       <= '0;
            r_is_remove <= 1'b0;
            r_ovalid    <= 1'b0;
            r_oword     <= '0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_rot       <= n_rot;
            r_is_remove <= n_is_remove;
            r_ovalid    <= n_ovalid;
            r_oword     <= n_oword;
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_oword;

    `ASSERT_ALWAYS(a_occ_bound, r_occ <= CW'(DEPTH))
    `ASSERT_IMPL(a_busy_out_free, r_state != S_IDLE, !r_ovalid)
    `ASSERT_NEXT(a_pop_dec, pop_take, r_occ == $past(r_occ) - 1'b1)
    `ASSERT_IMPL(a_full_count, r_ovalid && (r_oword.status == ST_FULL), r_oword.entry_count == ENTRY_W'(DEPTH))

endmodule

>>> rtl/fifo_queue_with_search_remove_unit.sv
// Push, pop, empty-queue and unused commands: the result word enters the output register in
//   the cycle after accept. Search/remove: one compare, DEPTH match-ripple steps, one finish.
//   Reverse of n entries: one setup, then n-1 rotate steps.
// One command at a time: a command is taken only while the sequencer is idle and no result
//   is held by i_stall; the match-flag ripple along the chain sets the search/remove time.
// Reset clears count, sequencer and output valid; slots are not reset.
module fifo_queue_with_search_remove_unit
    import fqsr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DEPTH       = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_word,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_word o_word,
    input  logic      i_stall
);

    localparam int CW = $clog2(DEPTH+1);

    // Cell chain: cell 0 holds the front of the queue. Each cell sees the
    // slot of its right neighbor (for shifts), the seen flag of its left
    // neighbor (for the first-match ripple) and the front slot (for rotate).
    logic [VALUE_WIDTH-1:0] slot [DEPTH];
    logic                   seen [DEPTH];

    t_cell_op               cell_op;
    logic [CW-1:0]          cell_pos;
    logic [VALUE_WIDTH-1:0] cell_key;

    // Sequencer: takes a word, drives the broadcast operation, keeps the
    // entry count and holds the result word until the far side takes it.
    fqsr_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DEPTH       (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_word      (i_word),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_stall     (i_stall),
        .i_front     (slot[0]),
        .i_last_seen (seen[DEPTH-1]),
        .o_op        (cell_op),
        .o_pos       (cell_pos),
        .o_key       (cell_key)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] right;
        logic                   left_seen;

        // last cell has no neighbor: it keeps its own value on a shift
        if (g == DEPTH-1) begin : g_last
            assign right = slot[g];
        end else begin : g_mid
            assign right = slot[g+1];
        end

        // the front cell starts the match ripple
        if (g == 0) begin : g_first
            assign left_seen = 1'b0;
        end else begin : g_rest
            assign left_seen = seen[g-1];
        end

        fqsr_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .DEPTH       (DEPTH),
            .IDX         (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (cell_op),
            .i_pos       (cell_pos),
            .i_key       (cell_key),
            .i_right     (right),
            .i_front     (slot[0]),
            .i_left_seen (left_seen),
            .o_slot      (slot[g]),
            .o_seen      (seen[g])
        );
    end

endmodule
